FILE: design/itfp_pkg.sv
// Shared types, constants and codes of the interval timer with fractional prescaler.
package itfp_pkg;

  // Field and register widths.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned OFF_W     = 3;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CPS_W     = 32;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned CNT16_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned PROD_W    = CPS_W + RATE_W;
  localparam int unsigned STEP_W    = $clog2(CPS_W);

  // Default width of the CPU cycle counter.
  localparam int unsigned CYCLE_WIDTH_DEF = 32;

  // Reset values of the configuration registers.
  localparam logic [CPS_W-1:0]  CPS_RESET  = 32'd1024000;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd10000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CPS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'b1;

  // Register offsets.
  localparam logic [OFF_W-1:0] OFF_IVL_LO  = 3'd0;
  localparam logic [OFF_W-1:0] OFF_IVL_HI  = 3'd1;
  localparam logic [OFF_W-1:0] OFF_CNT_LO  = 3'd2;
  localparam logic [OFF_W-1:0] OFF_CNT_HI  = 3'd3;
  localparam logic [OFF_W-1:0] OFF_SCRATCH = 3'd4;
  localparam logic [OFF_W-1:0] OFF_CTRL    = 3'd5;

  // Operation codes of an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic mul;
    logic div_step;
    logic div_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_due;
  } sts_t;

endpackage

FILE: design/itfp_if.sv
// Valid/ready channel interfaces for the timer's input and result beats.
interface itfp_in_if import itfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [OFF_W-1:0]  reg_offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output operation, output reg_offset, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input reg_offset, input write_data,
                  output ready);
endinterface

interface itfp_out_if import itfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_pulse;

  modport source (output valid, output read_data, output irq_pulse, input ready);
  modport sink   (input valid, input read_data, input irq_pulse, output ready);
endinterface

FILE: design/itfp_ctrl.sv
// Controller: accepts beats, sequences the boundary multiply and divide, owns the result valid.
module itfp_ctrl import itfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;

  // A beat is taken only while idle and the result register has room.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.tick_due) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(CPS_W - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/itfp_dp.sv
// Datapath: timer state, byte registers, prescaler and the radix-2 boundary divider.
module itfp_dp import itfp_pkg::*; #(
  parameter int unsigned CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [OFF_W-1:0]     reg_offset_i,
  input  logic [DATA_W-1:0]    write_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [DATA_W-1:0]    read_data_o,
  output logic                 irq_pulse_o
);

  localparam int unsigned CMP_W = (CYCLE_WIDTH > CPS_W) ? CYCLE_WIDTH : CPS_W;

  // Configuration registers.
  logic [CPS_W-1:0]  cps_q;
  logic [RATE_W-1:0] rate_q;

  // Architectural timer state.
  logic [CYCLE_WIDTH-1:0] cyc_q, cyc_d;
  logic [CPS_W-1:0]       bnd_q;
  logic [RATE_W-1:0]      phase_q, phase_d;
  logic [CNT16_W-1:0]     ivl_q, ivl_d;
  logic [CNT16_W-1:0]     tc_q, tc_d;
  logic                   en_q, en_d;
  logic [DATA_W-1:0]      scr_q, scr_d;

  // Boundary arithmetic operands and divider state.
  logic [CPS_W-1:0]  mul_a_q;
  logic [RATE_W-1:0] mul_b_q;
  logic [RATE_W-1:0] div_rate_q;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [CPS_W-1:0]  dq_q, dq_d;
  logic [PROD_W-1:0] prod;

  // Result register.
  logic [DATA_W-1:0] rd_q, rd_d;
  logic              irq_q, irq_d;

  // Prescaler terms for the beat at the input.
  logic [RATE_W-1:0] rate_eff;
  logic              due;
  logic [RATE_W:0]   ph_inc;
  logic              wrap;
  logic [RATE_W-1:0] ph_new;
  logic              hit;
  logic [RATE_W:0]   div_sh;
  logic              div_ge;
  logic [RATE_W:0]   div_sub;

  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign due      = (op_e'(operation_i) == OP_TICK) && (CMP_W'(cyc_q) >= CMP_W'(bnd_q));
  assign ph_inc   = {1'b0, phase_q} + 1'b1;
  assign wrap     = ph_inc >= {1'b0, rate_eff};
  assign ph_new   = wrap ? '0 : ph_inc[RATE_W-1:0];
  assign hit      = due && en_q && (tc_q >= ivl_q);
  assign sts_o.tick_due = due;

  // Beat execution: clock ticks, register writes and reads.
  always_comb begin
    cyc_d   = cyc_q;
    phase_d = phase_q;
    ivl_d   = ivl_q;
    tc_d    = tc_q;
    en_d    = en_q;
    scr_d   = scr_q;
    rd_d    = '0;
    irq_d   = 1'b0;
    case (op_e'(operation_i))
      OP_TICK: begin
        if (due) begin
          phase_d = ph_new;
          if (en_q) begin
            tc_d = (hit ? '0 : tc_q) + 1'b1;
          end
        end
        cyc_d = ((due && wrap) ? '0 : cyc_q) + 1'b1;
        irq_d = hit;
      end
      OP_WRITE: begin
        unique case (reg_offset_i)
          OFF_IVL_LO: begin
            ivl_d = {ivl_q[CNT16_W-1:DATA_W], write_data_i};
            if (ivl_d == '0) begin
              ivl_d = CNT16_W'(1);
            end
          end
          OFF_IVL_HI: begin
            ivl_d = {write_data_i, ivl_q[DATA_W-1:0]};
            if (ivl_d == '0) begin
              ivl_d = CNT16_W'(1);
            end
          end
          OFF_CNT_LO, OFF_CNT_HI: tc_d  = '0;
          OFF_SCRATCH:            scr_d = write_data_i;
          OFF_CTRL:               en_d  = write_data_i[0];
          default: ;
        endcase
      end
      OP_READ: begin
        unique case (reg_offset_i)
          OFF_IVL_LO:  rd_d = ivl_q[DATA_W-1:0];
          OFF_IVL_HI:  rd_d = ivl_q[CNT16_W-1:DATA_W];
          OFF_CNT_LO:  rd_d = tc_q[DATA_W-1:0];
          OFF_CNT_HI:  rd_d = tc_q[CNT16_W-1:DATA_W];
          OFF_SCRATCH: rd_d = scr_q;
          OFF_CTRL:    rd_d = {{(DATA_W-1){1'b0}}, en_q};
          default:     rd_d = '0;
        endcase
      end
      default: ;
    endcase
  end

  // Multiply the latched operands; the high part is below the rate, so it seeds the remainder.
  assign prod = mul_a_q * mul_b_q;

  // One restoring divide step per cycle.
  assign div_sh  = {rem_q, dq_q[CPS_W-1]};
  assign div_ge  = div_sh >= {1'b0, div_rate_q};
  assign div_sub = div_sh - {1'b0, div_rate_q};

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    if (cmd_i.mul) begin
      rem_d = prod[PROD_W-1:CPS_W];
      dq_d  = prod[CPS_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = div_ge ? div_sub[RATE_W-1:0] : div_sh[RATE_W-1:0];
      dq_d  = {dq_q[CPS_W-2:0], div_ge};
    end
  end

  // Configuration and timer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q   <= CPS_RESET;
      rate_q  <= RATE_RESET;
      cyc_q   <= '0;
      bnd_q   <= '0;
      phase_q <= '0;
      ivl_q   <= CNT16_W'(1);
      tc_q    <= '0;
      en_q    <= 1'b0;
      scr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CPS) begin
          cps_q <= cfg_data_i[CPS_W-1:0];
        end
        if (cfg_idx_i == CFG_RATE) begin
          rate_q <= cfg_data_i[RATE_W-1:0];
        end
      end
      if (cmd_i.exec) begin
        cyc_q   <= cyc_d;
        phase_q <= phase_d;
        ivl_q   <= ivl_d;
        tc_q    <= tc_d;
        en_q    <= en_d;
        scr_q   <= scr_d;
      end
      if (cmd_i.div_last) begin
        bnd_q <= dq_d;
      end
    end
  end

  // Operand latches, divider and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
      if (due) begin
        mul_a_q    <= cps_q;
        mul_b_q    <= RATE_W'({1'b0, ph_new} + 1'b1);
        div_rate_q <= rate_eff;
      end
    end
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign read_data_o = rd_q;
  assign irq_pulse_o = irq_q;

endmodule

FILE: design/interval_timer_with_fractional_prescaler_core.sv
// Top level of the 16-bit interval timer with a fractional CPU-cycle prescaler.
//
//   Port        Dir  Beat contents
//   in_i        in   operation, reg_offset, write_data (tick, register write or read)
//   out_o       out  read_data, irq_pulse (one result per input beat)
//   cfg_*_i     in   index 0 CPU clock rate in cycles per second, index 1 tick_rate
//
// A beat that crosses no prescaler boundary is done at accept. A clock tick that
// crosses a boundary goes through accept, one multiply of the CPU clock rate by
// the new phase plus one, then 32 steps of the radix-2 divider that yields the next
// boundary. Its result beat is ready in the cycle after accept, as the divider runs.
// A new beat is taken only while the output register is empty or being drained.
// Reset is asynchronous and puts the timer at phase 0 with the registers at defaults.
module interval_timer_with_fractional_prescaler_core import itfp_pkg::*; #(
  parameter int unsigned CYCLE_WIDTH = CYCLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  itfp_in_if.sink              in_i,
  itfp_out_if.source           out_o
);

  cmd_t cmd;
  sts_t sts;

  // Beat sequencing.
  itfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Timer state and arithmetic.
  itfp_dp #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .operation_i  (in_i.operation),
    .reg_offset_i (in_i.reg_offset),
    .write_data_i (in_i.write_data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (out_o.read_data),
    .irq_pulse_o  (out_o.irq_pulse)
  );

endmodule
